// ----- hw/rtl/tspb_pkg.sv -----
// ----------------------------------------------------------------------------
// tspb_pkg
// Shared types and codes of the two-sided price book.
// ----------------------------------------------------------------------------
package tspb_pkg;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_CHANGE = 2'd2;
  localparam logic [1:0] MODE_SHOW   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CROSS    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] volume;
  } order_t;

  // Command broadcast to every cell of one side for one cycle.
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t   cmd;
    logic        sell;   // ordering: 1 lowest price first
    order_t      ord;
  } side_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP1,
    S_OP2,
    S_OP3,
    S_SHOW,
    S_OUT
  } state_t;

endpackage

// ----- hw/rtl/tspb_cell.sv -----
// ----------------------------------------------------------------------------
// tspb_cell
// One slot of a sorted side: holds an order and shifts with its neighbors.
// ----------------------------------------------------------------------------
module tspb_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tspb_pkg::side_ctl_t ctl,
  input  logic               prev_valid,   // left neighbor state
  input  tspb_pkg::order_t    prev_ord,
  input  logic               prev_ins_here,// left neighbor takes the new order or shifted
  input  logic               prev_del_hit, // a delete match lies at or left of neighbor
  input  logic               next_valid,
  input  tspb_pkg::order_t    next_ord,
  output logic               valid,
  output tspb_pkg::order_t    ord,
  output logic               ins_here,
  output logic               del_hit
);
  import tspb_pkg::*;

  logic   valid_r, valid_nxt;
  order_t ord_r, ord_nxt;
  logic   goes_after;
  logic   match;

  // New order is placed before this one when this order is strictly worse.
  assign goes_after = ctl.sell ? (ord_r.price > ctl.ord.price)
                               : (ord_r.price < ctl.ord.price);
  assign ins_here = prev_ins_here | ~valid_r | goes_after;
  assign match    = valid_r && ord_r == ctl.ord;
  assign del_hit  = prev_del_hit | match;

  always_comb begin
    valid_nxt = valid_r;
    ord_nxt   = ord_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (prev_ins_here) begin
          ord_nxt   = prev_ord;
          valid_nxt = prev_valid;
        end else if (ins_here) begin
          ord_nxt   = ctl.ord;
          valid_nxt = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (del_hit) begin
          ord_nxt   = next_ord;
          valid_nxt = next_valid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    ord_r <= ord_nxt;
  end

  assign valid = valid_r;
  assign ord   = ord_r;
endmodule

// ----- hw/rtl/tspb_side.sv -----
// ----------------------------------------------------------------------------
// tspb_side
// A chain of cells holding one side of the book, best order first.
// ----------------------------------------------------------------------------
module tspb_side #(
  parameter int DEPTH = 64,
  parameter int SHOW  = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tspb_pkg::side_ctl_t  ctl,
  output logic                found,
  output logic                full,
  output logic                nonempty,
  output tspb_pkg::order_t     best,
  output logic [SHOW-1:0]     head_valid,
  output tspb_pkg::order_t     head_ord [SHOW]
);
  import tspb_pkg::*;

  logic   v   [DEPTH+1];
  order_t o   [DEPTH+1];
  logic   ins [DEPTH+1];
  logic   del [DEPTH+1];

  assign ins[0] = 1'b0;
  assign del[0] = 1'b0;
  assign v[DEPTH] = 1'b0;
  assign o[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic   pv;
    order_t po;
    if (g == 0) begin : g_head
      assign pv = 1'b1;
      assign po = ctl.ord;
    end else begin : g_body
      assign pv = v[g-1];
      assign po = o[g-1];
    end
    tspb_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .prev_valid(pv), .prev_ord(po),
      .prev_ins_here(ins[g]), .prev_del_hit(del[g]),
      .next_valid(v[g+1]), .next_ord(o[g+1]),
      .valid(v[g]), .ord(o[g]),
      .ins_here(ins[g+1]), .del_hit(del[g+1])
    );
  end

  assign found    = del[DEPTH];
  assign full     = v[DEPTH-1];
  assign nonempty = v[0];
  assign best     = o[0];

  for (genvar h = 0; h < SHOW; h++) begin : g_head_out
    if (h < DEPTH) begin : g_in
      assign head_valid[h] = v[h];
      assign head_ord[h]   = o[h];
    end else begin : g_out
      assign head_valid[h] = 1'b0;
      assign head_ord[h]   = '0;
    end
  end
endmodule

// ----- hw/rtl/two_sided_price_book_core.sv -----
// ----------------------------------------------------------------------------
// two_sided_price_book_core
// Limit order book with a buy side and a sell side held in cell chains.
// ----------------------------------------------------------------------------
// Each side is a chain of BOOK_DEPTH cells kept best first. Every cell compares
// its own order against a broadcast order and shifts right (insert) or left
// (delete) in step with the whole chain. An add or remove does the check and
// the shift in S_OP1 and then loads the output register in S_OUT. A change
// whose old order is found adds the new order in S_OP2 and, when that add
// fails, restores the old order in S_OP3 before S_OUT. A show item latches
// the best SHOW_PER_SIDE orders of each side in S_SHOW and then loads one
// result item per cycle while out_ready does not stall it, up to
// 2*SHOW_PER_SIDE items. A loaded result that waits for out_ready holds S_OUT.
// The next item is taken once the current item's last result has been loaded
// into the output register; that result may still be waiting for acceptance
// then. Reset empties both sides at once.
// ----------------------------------------------------------------------------
module two_sided_price_book_core #(
  parameter int BOOK_DEPTH    = 64,
  parameter int SHOW_PER_SIDE = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic               in_side,
  input  logic [31:0]        in_price,
  input  logic signed [31:0] in_volume,
  input  logic               in_new_side,
  input  logic [31:0]        in_new_price,
  input  logic signed [31:0] in_new_volume,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic               out_shown_side,
  output logic [31:0]        out_shown_price,
  output logic signed [31:0] out_shown_volume,
  output logic               out_last
);
  import tspb_pkg::*;

  localparam int NSHOW = 2 * SHOW_PER_SIDE;
  localparam int IW    = $clog2(NSHOW + 1);

  state_t state_r, state_nxt;

  // Accepted item.
  logic [1:0] mode_r;
  logic       side_r, nside_r;
  order_t     old_r, new_r;
  logic [2:0] st_r, st_nxt;

  side_ctl_t  ctl_b, ctl_s;
  logic       found_b, found_s, full_b, full_s, ne_b, ne_s;
  order_t     best_b, best_s;
  logic [SHOW_PER_SIDE-1:0] hv_b, hv_s;
  order_t     ho_b [SHOW_PER_SIDE];
  order_t     ho_s [SHOW_PER_SIDE];

  // Show list, already in output order.
  logic       lv_r  [NSHOW];
  logic       ls_r  [NSHOW];
  order_t     lo_r  [NSHOW];
  logic       lv_nxt [NSHOW];
  logic       ls_nxt [NSHOW];
  order_t     lo_nxt [NSHOW];
  logic [IW-1:0] sell_cnt, slot;
  logic [IW-1:0] idx_r, idx_nxt;

  logic       ov_r, ov_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic       osd_r, osd_nxt, olast_r, olast_nxt;
  order_t     oord_r, oord_nxt;

  tspb_side #(.DEPTH(BOOK_DEPTH), .SHOW(SHOW_PER_SIDE)) u_buy (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_b), .found(found_b), .full(full_b),
    .nonempty(ne_b), .best(best_b), .head_valid(hv_b), .head_ord(ho_b));
  tspb_side #(.DEPTH(BOOK_DEPTH), .SHOW(SHOW_PER_SIDE)) u_sell (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_s), .found(found_s), .full(full_s),
    .nonempty(ne_s), .best(best_s), .head_valid(hv_s), .head_ord(ho_s));

  assign in_ready = (state_r == S_IDLE);

  // Add check for side s with order p against the current book.
  function automatic logic [2:0] add_check(input logic s, input logic [31:0] p,
                                           input logic nb, input logic [31:0] bb,
                                           input logic ns, input logic [31:0] bs,
                                           input logic fb, input logic fs);
    if (s ? (nb && p <= bb) : (ns && p >= bs)) return ST_CROSS;
    if (s ? fs : fb) return ST_FULL;
    return ST_OK;
  endfunction

  logic [2:0] chk_new, chk_old;
  assign chk_new = add_check(nside_r, new_r.price, ne_b, best_b.price, ne_s,
                             best_s.price, full_b, full_s);
  assign chk_old = add_check(side_r, old_r.price, ne_b, best_b.price, ne_s,
                             best_s.price, full_b, full_s);

  // Pack the show list: sells worst to best among the head, then buys.
  always_comb begin
    sell_cnt = '0;
    slot     = '0;
    for (int j = 0; j < SHOW_PER_SIDE; j++) begin
      sell_cnt = sell_cnt + IW'(hv_s[j]);
    end
    for (int k = 0; k < NSHOW; k++) begin
      lv_nxt[k] = 1'b0;
      ls_nxt[k] = 1'b0;
      lo_nxt[k] = '0;
    end
    for (int j = 0; j < SHOW_PER_SIDE; j++) begin
      if (hv_s[j]) begin
        slot         = sell_cnt - IW'(1) - IW'(j);
        lv_nxt[slot] = 1'b1;
        ls_nxt[slot] = 1'b1;
        lo_nxt[slot] = ho_s[j];
      end
    end
    for (int k = 0; k < SHOW_PER_SIDE; k++) begin
      if (hv_b[k]) begin
        slot         = sell_cnt + IW'(k);
        lv_nxt[slot] = 1'b1;
        ls_nxt[slot] = 1'b0;
        lo_nxt[slot] = ho_b[k];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r;
    ost_nxt   = ost_r;
    osd_nxt   = osd_r;
    oord_nxt  = oord_r;
    olast_nxt = olast_r;
    ctl_b     = '{cmd: CMD_NONE, sell: 1'b0, ord: old_r};
    ctl_s     = '{cmd: CMD_NONE, sell: 1'b1, ord: old_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == MODE_SHOW) ? S_SHOW : S_OP1;
        end
      end
      S_OP1: begin
        // Add: check and insert; remove/change: delete the old order.
        if (mode_r == MODE_ADD) begin
          st_nxt = chk_old;
          if (chk_old == ST_OK) begin
            if (side_r) ctl_s.cmd = CMD_INSERT; else ctl_b.cmd = CMD_INSERT;
          end
          state_nxt = S_OUT;
        end else begin
          st_nxt = (side_r ? found_s : found_b) ? ST_OK : ST_NOTFOUND;
          if (side_r ? found_s : found_b) begin
            if (side_r) ctl_s.cmd = CMD_DELETE; else ctl_b.cmd = CMD_DELETE;
          end
          state_nxt = (mode_r == MODE_CHANGE && (side_r ? found_s : found_b))
                      ? S_OP2 : S_OUT;
        end
      end
      S_OP2: begin
        st_nxt = chk_new;
        ctl_b.ord = new_r;
        ctl_s.ord = new_r;
        if (chk_new == ST_OK) begin
          if (nside_r) ctl_s.cmd = CMD_INSERT; else ctl_b.cmd = CMD_INSERT;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_OP3;
        end
      end
      S_OP3: begin
        // Restore the old order; it fits since it was just removed.
        if (side_r) ctl_s.cmd = CMD_INSERT; else ctl_b.cmd = CMD_INSERT;
        state_nxt = S_OUT;
      end
      S_SHOW: begin
        idx_nxt = '0;
        if (!hv_b[0] && !hv_s[0]) begin
          st_nxt    = ST_EMPTY;
          state_nxt = S_OUT;
        end else begin
          st_nxt    = ST_OK;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          if (mode_r == MODE_SHOW && st_r == ST_OK) begin
            if (idx_r < IW'(NSHOW) && lv_r[idx_r[IW-1:0]]) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_OK;
              osd_nxt   = ls_r[idx_r];
              oord_nxt  = lo_r[idx_r];
              olast_nxt = (idx_r == IW'(NSHOW - 1)) || !lv_r[idx_r + IW'(1)];
              idx_nxt   = idx_r + IW'(1);
              if (olast_nxt) state_nxt = S_IDLE;
            end else begin
              ov_nxt = 1'b0;
            end
          end else begin
            ov_nxt    = 1'b1;
            ost_nxt   = st_r;
            osd_nxt   = 1'b0;
            oord_nxt  = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r != S_OUT && ov_r && out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r    <= st_nxt;
    idx_r   <= idx_nxt;
    ost_r   <= ost_nxt;
    osd_r   <= osd_nxt;
    oord_r  <= oord_nxt;
    olast_r <= olast_nxt;
    if (in_valid && in_ready) begin
      mode_r  <= in_mode;
      side_r  <= in_side;
      nside_r <= in_new_side;
      old_r   <= '{price: in_price, volume: in_volume};
      new_r   <= '{price: in_new_price, volume: in_new_volume};
    end
    if (state_r == S_SHOW) begin
      lv_r <= lv_nxt;
      ls_r <= ls_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_shown_side   = osd_r;
  assign out_shown_price  = oord_r.price;
  assign out_shown_volume = oord_r.volume;
  assign out_last         = olast_r;
endmodule

// ----- hw/rtl/tspb_checker.sv -----
// ----------------------------------------------------------------------------
// tspb_checker
// Port-level checks of the price book core, bound to the top level.
// ----------------------------------------------------------------------------
module tspb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status,
  input logic       out_last
);
  import tspb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_EMPTY)
    else $error("bad status code");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("new item taken mid show");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error result not last");
endmodule

bind two_sided_price_book_core tspb_checker u_tspb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_last(out_last));
